// ===== hw/rtl/pcst_pkg.sv =====
// Package for the producer/consumer shadow tracker.
// Holds the op codes, the shadow entry layout and the record types used across the modules.
// No dependencies.
package pcst_pkg;

    localparam int TIME_W  = 48;
    localparam int SEQ_W   = 32;
    localparam int BADDR_W = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // One shadow table entry per tracked byte.
    typedef struct packed {
        logic              produced;
        logic [TIME_W-1:0] ptime;
        logic [SEQ_W-1:0]  pseq;
        logic [SEQ_W-1:0]  cseq;
    } t_entry;

    // One consumption record.
    typedef struct packed {
        logic [BADDR_W-1:0] baddr;
        logic [TIME_W-1:0]  ptime;
        logic [TIME_W-1:0]  ctime;
        logic [SEQ_W-1:0]   pseq;
        logic [SEQ_W-1:0]   cseq;
    } t_rec;

    // Commands from the sequencer to the record buffer.
    typedef struct packed {
        logic push;
        logic flush;
    } t_rec_cmd;

endpackage

// ===== hw/rtl/pcst_shadow_mem.sv =====
// Shadow table memory: one entry per byte of the tracked address window.
// One write port, one read port, read data registered. Depends on pcst_pkg.
module pcst_shadow_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  pcst_pkg::t_entry     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output pcst_pkg::t_entry     o_rdata
);
    import pcst_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pcst_rec_out.sv =====
// Record buffer: holds one pending record until the next one or the end of the
// access shows whether it is the last, then moves it to the output register.
// Depends on pcst_pkg.
module pcst_rec_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcst_pkg::t_rec_cmd i_cmd,
    input  pcst_pkg::t_rec     i_rec,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output pcst_pkg::t_rec     o_rec,
    output logic               o_last
);
    import pcst_pkg::*;

    logic r_pend_vld, n_pend_vld;
    t_rec r_pend, n_pend;
    logic r_out_vld, n_out_vld;
    t_rec r_out, n_out;
    logic r_out_last, n_out_last;
    logic out_free;

    assign out_free = !r_out_vld || !i_stall;
    assign o_ready  = !r_pend_vld || out_free;

    always_comb begin
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_out_last = r_out_last;
        // drop the output once taken
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.push && o_ready) begin
            if (r_pend_vld) begin
                n_out      = r_pend;
                n_out_last = 1'b0;
                n_out_vld  = 1'b1;
            end
            n_pend     = i_rec;
            n_pend_vld = 1'b1;
        end else if (i_cmd.flush && o_ready && r_pend_vld) begin
            n_out      = r_pend;
            n_out_last = 1'b1;
            n_out_vld  = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_vld;
    assign o_rec   = r_out;
    assign o_last  = r_out_last;

endmodule

// ===== hw/rtl/producer_consumer_shadow_tracker_core.sv =====
// Producer/consumer shadow tracker, top level.
// Sequencer, counter and stack filter; uses pcst_pkg, pcst_shadow_mem, pcst_rec_out.
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per op: a tick,
//   a write access or a read access with its size, stack pointer and roles.
//   Output channel (o_valid / i_stall) carries one record per consumed byte
//   that was marked produced; o_last flags the final record of an access.
//   i_cfg_we / i_cfg_wdata write ignore_stack; write it only while idle.
// Operation:
//   Ticks, ignored accesses and zero-size accesses are handled in the idle state.
//   An access of n bytes (n saturated to MAX_ACCESS_BYTES) runs as: accept,
//   n reads of the shadow memory one byte a cycle unless the walk is stalled,
//   the write-back of the last byte, a drain step and the flush of the held record.
//   A record is held until the next one shows it is not the last.
// Reset: the block sweeps all 2**ADDR_BITS shadow memory entries clear, one
//   entry a cycle, holding o_stall high until done.
// Receiver stall: with one record in the output and one held, i_stall freezes
//   the walk at a byte that gives a record; no record is lost and its write waits.
module producer_consumer_shadow_tracker_core #(
    parameter int ADDR_BITS        = 16,
    parameter int MAX_ACCESS_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic [15:0]                  i_address,
    input  logic [3:0]                   i_access_size,
    input  logic [15:0]                  i_stack_pointer,
    input  logic                         i_is_prefetch,
    input  logic                         i_in_producer,
    input  logic                         i_in_consumer,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pcst_pkg::BADDR_W-1:0] o_byte_address,
    output logic [pcst_pkg::TIME_W-1:0]  o_production_time,
    output logic [pcst_pkg::TIME_W-1:0]  o_consumption_time,
    output logic [pcst_pkg::SEQ_W-1:0]   o_production_seq,
    output logic [pcst_pkg::SEQ_W-1:0]   o_consumption_seq,
    output logic                         o_last
);
    import pcst_pkg::*;

    localparam int AW  = ADDR_BITS;
    localparam int SZW = $clog2(MAX_ACCESS_BYTES + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [TIME_W-1:0] r_icount, n_icount;
    logic              r_ignore_stack;
    logic [AW-1:0]     r_base, n_base;
    logic [SZW-1:0]    r_size, n_size;
    logic [SZW-1:0]    r_iss_idx, n_iss_idx;
    logic              r_is_write, n_is_write;
    logic              r_producer, n_producer;
    logic              r_s1_vld, n_s1_vld;
    logic [AW-1:0]     r_s1_addr, n_s1_addr;

    // memory port signals
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    // record buffer signals
    t_rec_cmd rec_cmd;
    t_rec     rec_in;
    logic     rec_ready;
    t_rec     rec_out;

    // input decode
    logic           accept;
    logic           stack_hit;
    logic           is_access;
    logic [SZW-1:0] size_sat;

    // byte walk
    logic   issue;
    logic   s1_needs_rec;
    logic   advance;
    t_entry upd;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    assign stack_hit = r_ignore_stack && (i_address >= i_stack_pointer);
    assign size_sat  = (32'(i_access_size) > MAX_ACCESS_BYTES) ?
                       SZW'(MAX_ACCESS_BYTES) : SZW'(i_access_size);
    assign is_access = ((i_op == OP_WRITE) || (i_op == OP_READ && i_in_consumer))
                       && !i_is_prefetch && !stack_hit && (size_sat != '0);

    assign issue        = (r_iss_idx != r_size);
    assign s1_needs_rec = r_s1_vld && !r_is_write && mem_rdata.produced;
    assign advance      = !(s1_needs_rec && !rec_ready);

    // modify the entry read for the byte in stage 1
    always_comb begin
        upd = mem_rdata;
        if (r_is_write) begin
            if (r_producer) begin
                upd.produced = 1'b1;
                upd.ptime    = r_icount;
                upd.pseq     = mem_rdata.pseq + SEQ_W'(1);
            end else begin
                upd.produced = 1'b0;
            end
        end else begin
            upd.cseq = mem_rdata.cseq + SEQ_W'(1);
        end
    end

    assign rec_in.baddr = BADDR_W'(r_s1_addr);
    assign rec_in.ptime = mem_rdata.ptime;
    assign rec_in.ctime = r_icount;
    assign rec_in.pseq  = mem_rdata.pseq;
    assign rec_in.cseq  = upd.cseq;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_icount   = r_icount;
        n_base     = r_base;
        n_size     = r_size;
        n_iss_idx  = r_iss_idx;
        n_is_write = r_is_write;
        n_producer = r_producer;
        n_s1_vld   = 1'b0;
        n_s1_addr  = r_s1_addr;
        mem_we     = 1'b0;
        mem_waddr  = r_s1_addr;
        mem_wdata  = upd;
        mem_re     = 1'b0;
        mem_raddr  = r_base + AW'(r_iss_idx);
        rec_cmd    = '0;
        case (r_state)
            ST_CLEAR: begin
                // sweep zeros through the table
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_TICK) begin
                        n_icount = r_icount + TIME_W'(1);
                    end else if (is_access) begin
                        n_base     = AW'(i_address);
                        n_size     = size_sat;
                        n_iss_idx  = '0;
                        n_is_write = (i_op == OP_WRITE);
                        n_producer = i_in_producer;
                        n_state    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                n_s1_vld     = r_s1_vld;
                rec_cmd.push = s1_needs_rec;
                mem_we       = r_s1_vld && advance && (r_is_write || mem_rdata.produced);
                if (advance) begin
                    mem_re    = issue;
                    n_s1_vld  = issue;
                    n_s1_addr = mem_raddr;
                    if (issue) begin
                        n_iss_idx = r_iss_idx + SZW'(1);
                    end
                end
                if (!issue && !r_s1_vld) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // release the held record as the last one
                rec_cmd.flush = 1'b1;
                if (rec_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_icount       <= '0;
            r_ignore_stack <= 1'b1;
            r_iss_idx      <= '0;
            r_size         <= '0;
            r_s1_vld       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_icount   <= n_icount;
            r_iss_idx  <= n_iss_idx;
            r_size     <= n_size;
            r_s1_vld   <= n_s1_vld;
            if (i_cfg_we) begin
                r_ignore_stack <= i_cfg_wdata;
            end
        end
        r_base     <= n_base;
        r_is_write <= n_is_write;
        r_producer <= n_producer;
        r_s1_addr  <= n_s1_addr;
    end

    pcst_shadow_mem #(
        .ADDR_BITS(AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    pcst_rec_out u_rec (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (rec_cmd),
        .i_rec  (rec_in),
        .o_ready(rec_ready),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rec  (rec_out),
        .o_last (o_last)
    );

    assign o_byte_address     = rec_out.baddr;
    assign o_production_time  = rec_out.ptime;
    assign o_consumption_time = rec_out.ctime;
    assign o_production_seq   = rec_out.pseq;
    assign o_consumption_seq  = rec_out.cseq;

    // A new transaction never arrives while a byte is still in flight.
    a_no_accept_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_s1_vld && (r_iss_idx == r_size))
        else $error("transaction accepted while a byte walk is in flight");

    // Stage 1 only holds a byte during the walk.
    a_s1_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !r_s1_vld)
        else $error("stage 1 valid outside the byte walk");

    // A stalled stage 1 holds its address and issues no new read.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !advance) |=> r_s1_vld && $stable(r_s1_addr))
        else $error("stalled byte lost its place");

    // The issue index never runs past the access size.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_idx <= r_size)
        else $error("issue index beyond access size");

endmodule

// ===== sim/testbench.sv =====
// Testbench for producer_consumer_shadow_tracker_core.
// Drives tick, write and read transactions, predicts the consumption records from a
// shadow copy of the byte table and checks every record; uses pcst_pkg.
module testbench;
    import pcst_pkg::*;

    localparam int MAX_BYTES    = 8;
    localparam int QUIET_LIMIT  = 400000;  // covers the clearing sweep after reset
    localparam int DRAIN_CYCLES = 24;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [3:0]  size;
        logic [15:0] sp;
        logic        prefetch;
        logic        producer;
        logic        consumer;
    } t_access;

    typedef struct packed {
        t_rec rec;
        logic last;
    } t_expected_rec;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic               i_cfg_wdata     = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic [1:0]         i_op            = OP_TICK;
    logic [15:0]        i_address       = '0;
    logic [3:0]         i_access_size   = '0;
    logic [15:0]        i_stack_pointer = '0;
    logic               i_is_prefetch   = 1'b0;
    logic               i_in_producer   = 1'b0;
    logic               i_in_consumer   = 1'b0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic [BADDR_W-1:0] o_byte_address;
    logic [TIME_W-1:0]  o_production_time;
    logic [TIME_W-1:0]  o_consumption_time;
    logic [SEQ_W-1:0]   o_production_seq;
    logic [SEQ_W-1:0]   o_consumption_seq;
    logic               o_last;

    // Shadow copy of the block state, kept in step with every accepted transaction.
    bit              stack_filter = 1'b1;
    bit [TIME_W-1:0] instr_count;
    bit              byte_marked   [0:65535];
    bit [TIME_W-1:0] produce_stamp [0:65535];
    bit [SEQ_W-1:0]  produce_seq   [0:65535];
    bit [SEQ_W-1:0]  consume_seq   [0:65535];

    // Records still owed by the block, oldest first.
    t_expected_rec pending_records [$];

    int          mismatches      = 0;
    int          quiet_cycles    = 0;
    bit          sender_idling   = 1'b1;
    bit          receiver_idling = 1'b1;
    int          stall_left      = 0;
    int          calm_left       = 0;
    logic [15:0] hot_base [0:7];

    producer_consumer_shadow_tracker_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_op               (i_op),
        .i_address          (i_address),
        .i_access_size      (i_access_size),
        .i_stack_pointer    (i_stack_pointer),
        .i_is_prefetch      (i_is_prefetch),
        .i_in_producer      (i_in_producer),
        .i_in_consumer      (i_in_consumer),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_byte_address     (o_byte_address),
        .o_production_time  (o_production_time),
        .o_consumption_time (o_consumption_time),
        .o_production_seq   (o_production_seq),
        .o_consumption_seq  (o_consumption_seq),
        .o_last             (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the shadow state by one transaction and queue the records it causes.
    // Hold back each record by one hit so the final one of the access gets its last flag.
    function automatic void track_access(t_access a);
        int            n;
        logic [15:0]   b;
        t_expected_rec held;
        bit            have_held;
        have_held = 1'b0;
        if (a.op == OP_TICK) begin
            instr_count = instr_count + TIME_W'(1);
            return;
        end
        // Drop the unused op, prefetches, filtered stack accesses and foreign reads.
        if ((a.op != OP_WRITE && a.op != OP_READ) || a.prefetch) return;
        if (stack_filter && a.addr >= a.sp) return;
        if (a.op == OP_READ && !a.consumer) return;
        // Saturate oversize accesses; byte addresses wrap inside the window.
        n = (a.size > MAX_BYTES) ? MAX_BYTES : int'(a.size);
        for (int k = 0; k < n; k++) begin
            b = a.addr + 16'(k);
            if (a.op == OP_WRITE) begin
                byte_marked[b] = a.producer;
                if (a.producer) begin
                    produce_seq[b]   = produce_seq[b] + SEQ_W'(1);
                    produce_stamp[b] = instr_count;
                end
            end else if (byte_marked[b]) begin
                consume_seq[b] = consume_seq[b] + SEQ_W'(1);
                if (have_held) pending_records.push_back(held);
                held.rec  = '{baddr: b, ptime: produce_stamp[b], ctime: instr_count,
                              pseq: produce_seq[b], cseq: consume_seq[b]};
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_records.push_back(held);
        end
    endfunction

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Offer one transaction, optionally after a random gap, and hold it until accepted.
    task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [3:0] size,
                             logic [15:0] sp, logic prefetch, logic producer,
                             logic consumer);
        int gap;
        if (sender_idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_op            = op;
        i_address       = addr;
        i_access_size   = size;
        i_stack_pointer = sp;
        i_is_prefetch   = prefetch;
        i_in_producer   = producer;
        i_in_consumer   = consumer;
        i_valid         = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        track_access('{op, addr, size, sp, prefetch, producer, consumer});
    endtask

    // Withdraw the sender, wait for every owed record, then let the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_stack_filter(bit value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        stack_filter = value;
    endtask

    // Hold reset, then wait out the clearing sweep before the first register write.
    task automatic apply_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        set_stack_filter(1'b1);
    endtask

    // Producer writes, consumer reads back: records, counts and unmarked bytes.
    task automatic test_handoff();
        send_item(OP_TICK, 16'h0000, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(OP_TICK, 16'hFFFF, 4'd15, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_item(OP_WRITE, 16'h0100, 4'd4, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        send_item(OP_TICK, 16'h0000, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(OP_READ, 16'h0100, 4'd8, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_item(OP_READ, 16'h0101, 4'd2, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    endtask

    // Reads by others, prefetches, the unused op, zero size, clearing writes, stack filter.
    task automatic test_ignored_accesses();
        send_item(OP_READ, 16'h0100, 4'd4, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        send_item(OP_READ, 16'h0100, 4'd4, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        send_item(OP_UNUSED, 16'h0100, 4'd4, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        send_item(OP_WRITE, 16'h0300, 4'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        send_item(OP_WRITE, 16'h0102, 4'd1, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_item(OP_READ, 16'h0100, 4'd4, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_item(OP_READ, 16'h0100, 4'd4, 16'h0100, 1'b0, 1'b0, 1'b1);
    endtask

    // Oversize accesses, wrap at the top of the window, a function with both roles.
    task automatic test_size_and_wrap();
        send_item(OP_WRITE, 16'hFFFC, 4'd15, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        send_item(OP_TICK, 16'h0000, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_item(OP_READ, 16'hFFFE, 4'd9, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        send_item(OP_READ, 16'h0000, 4'd1, 16'h0001, 1'b0, 1'b0, 1'b1);
    endtask

    // With the filter off, accesses at or above the stack pointer count; then turn it back on.
    task automatic test_stack_filter();
        set_stack_filter(1'b0);
        send_item(OP_WRITE, 16'hFFFF, 4'd1, 16'h0000, 1'b0, 1'b1, 1'b0);
        send_item(OP_READ, 16'hFFFF, 4'd2, 16'h0000, 1'b0, 1'b0, 1'b1);
        set_stack_filter(1'b1);
        send_item(OP_READ, 16'hFFFF, 4'd1, 16'h0000, 1'b0, 1'b0, 1'b1);
    endtask

    // Mostly producer/consumer traffic around a few hot regions, plus ticks and noise.
    task automatic send_random_item();
        int          pick;
        logic [15:0] addr;
        logic [15:0] sp;
        logic [3:0]  size;
        pick = $urandom_range(0, 99);
        addr = hot_base[$urandom_range(0, 7)] + 16'($urandom_range(0, 7));
        // Keep the stack pointer above the access most of the time.
        if (addr == 16'hFFFF || $urandom_range(0, 9) == 0) sp = 16'($urandom);
        else sp = 16'($urandom_range(65535, int'(addr) + 1));
        if ($urandom_range(0, 11) == 0) size = 4'($urandom_range(0, 15));
        else size = 4'($urandom_range(1, 8));
        if (pick < 15)
            send_item(OP_TICK, 16'($urandom), 4'($urandom), 16'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 45)
            send_item(OP_WRITE, addr, size, sp, $urandom_range(0, 15) == 0,
                      $urandom_range(0, 7) != 0, 1'($urandom));
        else if (pick < 80)
            send_item(OP_READ, addr, size, sp, $urandom_range(0, 15) == 0,
                      1'($urandom), $urandom_range(0, 7) != 0);
        else
            send_item(2'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_random_traffic(int count, bit idling, bit pause_midway);
        sender_idling   = idling;
        receiver_idling = idling;
        hot_base[0] = 16'h0000;
        hot_base[1] = 16'hFFFA;
        for (int k = 2; k < 8; k++) hot_base[k] = 16'($urandom);
        for (int k = 0; k < count; k++) begin
            // Hold the sender once until the block owes nothing.
            if (pause_midway && k == count / 2) wait_idle();
            send_random_item();
        end
    endtask

    // Receiver stall: random bursts with calm stretches between.
    always @(negedge i_clk) begin
        if (!receiver_idling) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
            i_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    stall_left = $urandom_range(0, 18);
                    i_stall <= 1'b1;
                end
                2: begin
                    calm_left = $urandom_range(20, 80);
                    i_stall <= 1'b0;
                end
                default: begin
                    i_stall <= 1'b0;
                end
            endcase
        end
    end

    // Watchdog and record check, both on the rising edge.
    always @(posedge i_clk) begin
        t_expected_rec want;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (pending_records.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected record, expected none, actual address %0h",
                         $time, o_byte_address);
            end else begin
                want = pending_records.pop_front();
                check_field("byte_address", TIME_W'(want.rec.baddr),
                            TIME_W'(o_byte_address));
                check_field("production_time", want.rec.ptime, o_production_time);
                check_field("consumption_time", want.rec.ctime, o_consumption_time);
                check_field("production_seq", TIME_W'(want.rec.pseq),
                            TIME_W'(o_production_seq));
                check_field("consumption_seq", TIME_W'(want.rec.cseq),
                            TIME_W'(o_consumption_seq));
                check_field("last", TIME_W'(want.last), TIME_W'(o_last));
            end
        end
    end

    initial begin
        apply_reset();
        test_handoff();
        test_ignored_accesses();
        test_size_and_wrap();
        test_stack_filter();
        test_random_traffic(150, 1'b1, 1'b1);
        set_stack_filter(1'b0);
        test_random_traffic(150, 1'b1, 1'b0);
        set_stack_filter(1'b1);
        // Run the tail back to back on both sides.
        test_random_traffic(80, 1'b0, 1'b0);
        wait_idle();
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pcst_pkg.sv
hw/rtl/pcst_shadow_mem.sv
hw/rtl/pcst_rec_out.sv
hw/rtl/producer_consumer_shadow_tracker_core.sv
sim/testbench.sv
